// File: design/psce_pkg.sv
// shared types and constants for the point set centroid engine
// no dependencies
package psce_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQACC,
        ST_SHIFT,
        ST_SQRT,
        ST_ABSORB,
        ST_UDIV,
        ST_UACC,
        ST_MEAN,
        ST_RSDIV,
        ST_UMDIV,
        ST_EMIT
    } state_t;

    localparam int unsigned Q_ONE      = 65536;
    localparam int unsigned DIV_W      = 64;

    typedef struct packed {
        logic start;
        logic neg;
    } div_ctl_t;

endpackage

// File: design/psce_div.sv
// unsigned restoring divider, one quotient bit per cycle
// depends on psce_pkg
module psce_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  psce_pkg::div_ctl_t        ctl,
    input  logic [psce_pkg::DIV_W-1:0] dividend,
    input  logic [psce_pkg::DIV_W-1:0] divisor,
    output logic                      done,
    output logic [psce_pkg::DIV_W-1:0] quotient
);
    import psce_pkg::*;

    logic [DIV_W-1:0] q_reg, q_next;
    logic [DIV_W-1:0] r_reg, r_next;
    logic [DIV_W-1:0] d_reg, d_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             neg_reg, neg_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   shifted;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done      = 1'b0;
        shifted   = {r_reg, q_reg[DIV_W-1]};
        trial     = shifted - {1'b0, d_reg};
        if (ctl.start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 7'(DIV_W);
            busy_next = 1'b1;
            neg_next  = ctl.neg;
        end
        else if (busy_reg)
        begin
            // partial remainder stays below the divisor, so it fits in DIV_W bits
            if (!trial[DIV_W])
            begin
                r_next = trial[DIV_W-1:0];
                q_next = {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted[DIV_W-1:0];
                q_next = {q_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
                busy_next = 1'b0;
        end
        else if (cnt_reg == 7'd0 && d_reg != '0)
        begin
            done = 1'b1;
        end
    end

    // quotient negated on request
    assign quotient = neg_reg ? (~q_reg + 64'd1) : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
            neg_reg  <= 1'b0;
            d_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= done ? 7'd0 : cnt_next;
            neg_reg  <= neg_next;
            d_reg    <= done ? '0 : d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end
endmodule

// File: design/point_set_centroid_engine.sv
// point set centroid engine top level: sequencer, per-dimension stores
// depends on psce_pkg and psce_div
//
// Components arrive one per start pulse while busy is low. A component that
// does not complete a point holds busy for one cycle. A completed point
// takes an accumulate step, normalize-shift steps, an integer square root and
// an absorb step, then per dimension a division on the shared divider plus an
// accumulate step, or only the accumulate step when the norm is zero. A point
// dropped at capacity skips the per-dimension work. A point carrying the set
// end then runs, per dimension, mean, range and unit-mean divisions (the range
// one skipped when max equals min) plus an emit step, and emits one result
// strobe per dimension; the receiver cannot stall, results appear once each.
module point_set_centroid_engine #(
    parameter int MAX_DIMS   = 16,
    parameter int MAX_POINTS = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic signed [31:0] component,
    input  logic        last_in_set,
    output logic        strobe,
    output logic [3:0]  dim_index,
    output logic signed [31:0] mean,
    output logic signed [17:0] range_scaled,
    output logic signed [17:0] unit_mean,
    output logic [16:0] point_count,
    output logic        overflow,
    output logic        last
);
    import psce_pkg::*;

    localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    state_t state_reg, state_next;

    logic [4:0]          dims_reg;
    logic [DW-1:0]       ed_m1;
    logic signed [31:0]  pbuf_reg [MAX_DIMS];
    logic signed [47:0]  dsum_reg [MAX_DIMS];
    logic signed [31:0]  dmin_reg [MAX_DIMS];
    logic signed [31:0]  dmax_reg [MAX_DIMS];
    logic signed [33:0]  usum_reg [MAX_DIMS];
    logic [63:0]         sq_reg;
    logic [CW-1:0]       cnt_reg;
    logic [DW-1:0]       idx_reg;
    logic                drop_reg;
    logic                lastf_reg;
    logic [DW-1:0]       j_reg;
    logic [63:0]         mag_sq;
    logic [4:0]          s_reg;
    logic [63:0]         x_reg, res_reg, bit_reg;
    logic [63:0]         norm_reg;
    logic signed [31:0]  mean_reg;
    logic signed [17:0]  rs_reg;
    logic signed [17:0]  um_reg;

    div_ctl_t            dctl;
    logic [63:0]         dvd, dvs, quo;
    logic                ddone;

    psce_div u_div (
        .clk(clk), .rst_n(rst_n), .ctl(dctl), .dividend(dvd), .divisor(dvs),
        .done(ddone), .quotient(quo)
    );

    // effective dims minus one
    always_comb
    begin
        if (dims_reg == 5'd0)
            ed_m1 = '0;
        else if (32'(dims_reg) > MAX_DIMS)
            ed_m1 = DW'(MAX_DIMS - 1);
        else
            ed_m1 = DW'(dims_reg - 5'd1);
    end

    assign cfg_ready = (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);

    logic signed [31:0] cj;
    logic [31:0]        cmag;
    logic signed [63:0] sum64, smin64, span64, num64, us64;
    logic [31:0]        magc;
    assign cj     = pbuf_reg[j_reg];
    assign magc   = cj[31] ? (~cj + 32'd1) : cj;
    assign cmag   = component[31] ? (~component + 32'd1) : component;
    assign sum64  = 64'(dsum_reg[j_reg]);
    assign us64   = 64'(usum_reg[j_reg]);
    assign smin64 = 64'(dmin_reg[j_reg]);
    assign span64 = 64'(dmax_reg[j_reg]) - smin64;
    assign num64  = (64'(mean_reg) - smin64) <<< 17;

    // divider operands per phase
    always_comb
    begin
        dvd  = '0;
        dvs  = '0;
        unique case (state_reg)
            ST_UDIV:
            begin
                dvd = {16'd0, magc, 16'd0};
                dvs = norm_reg;
            end
            ST_MEAN:
            begin
                dvd = sum64[63] ? -sum64 : sum64;
                dvs = 64'(cnt_reg);
            end
            ST_RSDIV:
            begin
                dvd = num64;
                dvs = span64;
            end
            ST_UMDIV:
            begin
                dvd = us64[63] ? -us64 : us64;
                dvs = 64'(cnt_reg);
            end
            default: ;
        endcase
    end

    logic [63:0] sh_x, trial_b, norm_w;
    assign sh_x    = sq_reg << s_reg;
    assign trial_b = res_reg + bit_reg;
    assign norm_w  = res_reg << ((5'd16 - s_reg) >> 1);

    logic div_go_reg;
    logic signed [63:0] uq;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_SQACC;
            ST_SQACC:  state_next = (idx_reg == ed_m1) ? ST_SHIFT : ST_IDLE;
            ST_SHIFT:
                if (s_reg == 5'd0 || (sh_x >> s_reg) == sq_reg &&
                    (sq_reg >> (7'd64 - 7'(s_reg))) == 64'd0)
                    state_next = ST_SQRT;
            ST_SQRT:   if (bit_reg == 64'd0) state_next = ST_ABSORB;
            ST_ABSORB:
                // a point beyond capacity skips the statistics
                if (32'(cnt_reg) >= MAX_POINTS)
                    state_next = lastf_reg ? ST_MEAN : ST_IDLE;
                else
                    state_next = (norm_w != 64'd0) ? ST_UDIV : ST_UACC;
            ST_UDIV:   if (ddone) state_next = ST_UACC;
            ST_UACC:
                if (j_reg != ed_m1)
                    state_next = (norm_reg != 64'd0) ? ST_UDIV : ST_UACC;
                else if (lastf_reg)
                    state_next = ST_MEAN;
                else
                    state_next = ST_IDLE;
            ST_MEAN:   if (ddone) state_next = (span64 > 0) ? ST_RSDIV : ST_UMDIV;
            ST_RSDIV:  if (ddone) state_next = ST_UMDIV;
            ST_UMDIV:  if (ddone) state_next = ST_EMIT;
            ST_EMIT:   state_next = (j_reg == ed_m1) ? ST_IDLE : ST_MEAN;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign uq = us64;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            dims_reg   <= 5'd1;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            drop_reg   <= 1'b0;
            sq_reg     <= '0;
            div_go_reg <= 1'b0;
            strobe     <= 1'b0;
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                dsum_reg[i] <= '0;
                usum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            strobe    <= 1'b0;
            div_go_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                dims_reg <= cfg_data;
                cnt_reg  <= '0;
                idx_reg  <= '0;
                drop_reg <= 1'b0;
                sq_reg   <= '0;
                for (int i = 0; i < MAX_DIMS; i++)
                begin
                    dsum_reg[i] <= '0;
                    usum_reg[i] <= '0;
                end
            end
            unique case (state_reg)
                ST_IDLE:
                    if (start)
                    begin
                        if (idx_reg > ed_m1)
                            idx_reg <= '0;
                        mag_sq <= 64'(cmag) * 64'(cmag);
                    end
                ST_SQACC:
                begin
                    sq_reg <= sq_reg + (mag_sq >> 16);
                    s_reg  <= 5'd16;
                    if (idx_reg != ed_m1)
                        idx_reg <= idx_reg + DW'(1);
                end
                ST_SHIFT:
                begin
                    if (!(s_reg == 5'd0 || (sq_reg >> (7'd64 - 7'(s_reg))) == 64'd0))
                        s_reg <= s_reg - 5'd2;
                    x_reg   <= sh_x;
                    res_reg <= '0;
                    bit_reg <= 64'd1 << 62;
                end
                ST_SQRT:
                begin
                    if (bit_reg > x_reg && res_reg == 64'd0)
                        bit_reg <= bit_reg >> 2;
                    else if (bit_reg != 64'd0)
                    begin
                        if (x_reg >= trial_b)
                        begin
                            x_reg   <= x_reg - trial_b;
                            res_reg <= (res_reg >> 1) + bit_reg;
                        end
                        else
                            res_reg <= res_reg >> 1;
                        bit_reg <= bit_reg >> 2;
                    end
                    else
                        ;
                    j_reg <= '0;
                end
                ST_ABSORB:
                begin
                    norm_reg   <= norm_w;
                    sq_reg     <= '0;
                    idx_reg    <= '0;
                    div_go_reg <= 1'b1;
                    if (32'(cnt_reg) >= MAX_POINTS)
                        drop_reg <= 1'b1;
                end
                ST_UDIV: ;
                ST_UACC:
                begin
                    j_reg      <= j_reg + DW'(1);
                    div_go_reg <= 1'b1;
                    if (j_reg == ed_m1)
                    begin
                        j_reg <= '0;
                        if (32'(cnt_reg) < MAX_POINTS)
                            cnt_reg <= cnt_reg + CW'(1);
                    end
                    if (32'(cnt_reg) < MAX_POINTS)
                    begin
                        dsum_reg[j_reg] <= dsum_reg[j_reg] + 48'(cj);
                        if (cnt_reg == '0 || cj < dmin_reg[j_reg]) dmin_reg[j_reg] <= cj;
                        if (cnt_reg == '0 || cj > dmax_reg[j_reg]) dmax_reg[j_reg] <= cj;
                        if (norm_reg != 64'd0)
                        begin
                            if (quo > 64'(Q_ONE))
                                usum_reg[j_reg] <= usum_reg[j_reg] +
                                    (cj[31] ? -34'(Q_ONE) : 34'(Q_ONE));
                            else
                                usum_reg[j_reg] <= usum_reg[j_reg] +
                                    (cj[31] ? -34'(quo) : 34'(quo));
                        end
                    end
                end
                ST_MEAN:
                    if (ddone)
                    begin
                        mean_reg   <= sum64[63] ? -32'(quo) : 32'(quo);
                        rs_reg     <= '0;
                        div_go_reg <= 1'b1;
                    end
                ST_RSDIV:
                    if (ddone)
                    begin
                        rs_reg     <= 18'(quo) - 18'(Q_ONE);
                        div_go_reg <= 1'b1;
                    end
                ST_UMDIV:
                    if (ddone)
                        um_reg <= uq[63] ? -18'(quo) : 18'(quo);
                ST_EMIT:
                begin
                    strobe       <= 1'b1;
                    dim_index    <= 4'(j_reg);
                    mean         <= mean_reg;
                    range_scaled <= rs_reg;
                    unit_mean    <= um_reg;
                    point_count  <= 17'(cnt_reg);
                    overflow     <= drop_reg;
                    last         <= (j_reg == ed_m1);
                    j_reg        <= j_reg + DW'(1);
                    div_go_reg   <= 1'b1;
                    if (j_reg == ed_m1)
                    begin
                        j_reg      <= '0;
                        cnt_reg    <= '0;
                        drop_reg   <= 1'b0;
                        div_go_reg <= 1'b0;
                        for (int i = 0; i < MAX_DIMS; i++)
                        begin
                            dsum_reg[i] <= '0;
                            usum_reg[i] <= '0;
                        end
                    end
                end
                default: ;
            endcase
            if (state_reg == ST_IDLE && start)
                lastf_reg <= last_in_set;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
            pbuf_reg[(idx_reg > ed_m1) ? '0 : idx_reg] <= component;
    end

    // divider launch on entering a divide phase, flagged by div_go_reg
    always_comb
    begin
        dctl.start = div_go_reg && (state_reg == ST_UDIV || state_reg == ST_MEAN ||
                     state_reg == ST_RSDIV || state_reg == ST_UMDIV);
        dctl.neg   = 1'b0;
    end
endmodule

// File: tb/testbench.sv
// self-checking testbench for point_set_centroid_engine
// depends on psce_pkg and the engine rtl; predicts every result word and compares
`timescale 1ns / 100ps

module testbench;
    import psce_pkg::*;

    localparam int NDIM = 16;
    localparam int CAP  = 65536;
    localparam int Q1   = 65536;

    typedef struct {
        logic [3:0]         dim;
        logic signed [31:0] avg;
        logic signed [17:0] rs;
        logic signed [17:0] um;
        logic [16:0]        cnt;
        logic               ovf;
        logic               lst;
    } centroid_t;

    typedef struct {
        logic signed [31:0] comp;
        logic               mark;
        logic               fixed;
        logic signed [31:0] mean0;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [4:0] cfg_data = 5'd1;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] component = '0;
    logic last_in_set = 1'b0;
    logic strobe;
    logic [3:0] dim_index;
    logic signed [31:0] mean;
    logic signed [17:0] range_scaled;
    logic signed [17:0] unit_mean;
    logic [16:0] point_count;
    logic overflow;
    logic last;

    point_set_centroid_engine u_top (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .start(start), .busy(busy), .component(component),
        .last_in_set(last_in_set), .strobe(strobe), .dim_index(dim_index),
        .mean(mean), .range_scaled(range_scaled), .unit_mean(unit_mean),
        .point_count(point_count), .overflow(overflow), .last(last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #200ms;
        $display("testbench: FAIL");
        $finish;
    end

    // predictor state
    logic [4:0]         dims_reg;
    logic signed [63:0] pt_buf [NDIM];
    logic signed [63:0] sum_acc [NDIM];
    logic signed [63:0] min_acc [NDIM];
    logic signed [63:0] max_acc [NDIM];
    logic signed [63:0] unit_acc [NDIM];
    logic [63:0]        sq_acc;
    int unsigned        n_pts;
    int unsigned        pos;
    bit                 dropped;

    centroid_t expected_q [$];
    int errors = 0;
    int n_results = 0;
    int n_sets = 0;

    function automatic int unsigned dims_eff();
        if (dims_reg == 0) return 1;
        if (dims_reg > NDIM) return NDIM;
        return dims_reg;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void clear_stats();
        for (int j = 0; j < NDIM; j++)
        begin
            sum_acc[j] = 0;
            unit_acc[j] = 0;
        end
        sq_acc = 0;
        n_pts = 0;
        pos = 0;
        dropped = 0;
    endfunction

    function automatic void fold_point(int unsigned d);
        int unsigned s;
        logic [63:0] nrm;
        logic signed [63:0] c;
        logic signed [63:0] u;
        s = 16;
        while (s > 0 && (sq_acc >> (64 - s)) != 0) s = s - 2;
        nrm = int_sqrt(sq_acc << s) << ((16 - s) / 2);
        for (int j = 0; j < d; j++)
        begin
            c = pt_buf[j];
            u = 0;
            sum_acc[j] += c;
            if (n_pts == 0 || c < min_acc[j]) min_acc[j] = c;
            if (n_pts == 0 || c > max_acc[j]) max_acc[j] = c;
            if (nrm != 0)
            begin
                u = (c * Q1) / $signed(nrm);
                if (u > Q1) u = Q1;
                if (u < -Q1) u = -Q1;
            end
            unit_acc[j] += u;
        end
        n_pts++;
    endfunction

    // returns number of results queued
    function automatic int predict_centroid(logic signed [31:0] comp, logic mark);
        int unsigned d;
        int unsigned k;
        logic signed [63:0] c;
        logic [63:0] mag;
        logic signed [63:0] n;
        logic signed [63:0] avg;
        logic signed [63:0] span;
        logic signed [63:0] rsv;
        logic signed [63:0] umv;
        centroid_t r;
        d = dims_eff();
        k = pos;
        c = comp;
        mag = c < 0 ? -c : c;
        if (k >= d) k = 0;
        pt_buf[k] = c;
        sq_acc += (mag * mag) >> 16;
        if (k + 1 < d)
        begin
            pos = k + 1;
            return 0;
        end
        pos = 0;
        if (n_pts < CAP) fold_point(d);
        else dropped = 1;
        sq_acc = 0;
        if (!mark) return 0;
        n = n_pts;
        for (int j = 0; j < d; j++)
        begin
            avg = sum_acc[j] / n;
            span = max_acc[j] - min_acc[j];
            rsv = 0;
            if (span > 0) rsv = ((avg - min_acc[j]) * 2 * Q1) / span - Q1;
            umv = unit_acc[j] / n;
            r.dim = 4'(j);
            r.avg = avg[31:0];
            r.rs = rsv[17:0];
            r.um = umv[17:0];
            r.cnt = 17'(n_pts);
            r.ovf = dropped;
            r.lst = (j + 1 == d);
            expected_q.push_back(r);
        end
        clear_stats();
        n_sets++;
        return int'(d);
    endfunction

    // result monitor
    always @(posedge clk)
    begin
        centroid_t e;
        if (rst_n && strobe)
        begin
            n_results++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result word dim_index=%0d", dim_index);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (dim_index !== e.dim)
                begin
                    $error("dim_index exp %0d got %0d", e.dim, dim_index); errors++;
                end
                if (mean !== e.avg)
                begin
                    $error("mean exp %0d got %0d", e.avg, mean); errors++;
                end
                if (range_scaled !== e.rs)
                begin
                    $error("range_scaled exp %0d got %0d", e.rs, range_scaled); errors++;
                end
                if (unit_mean !== e.um)
                begin
                    $error("unit_mean exp %0d got %0d", e.um, unit_mean); errors++;
                end
                if (point_count !== e.cnt)
                begin
                    $error("point_count exp %0d got %0d", e.cnt, point_count); errors++;
                end
                if (overflow !== e.ovf)
                begin
                    $error("overflow exp %0d got %0d", e.ovf, overflow); errors++;
                end
                if (last !== e.lst)
                begin
                    $error("last exp %0d got %0d", e.lst, last); errors++;
                end
            end
        end
    end

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) g = 0;
        repeat (g) @(posedge clk);
    endtask

    // one component word; start drops for a cycle while the engine is busy anyway
    task automatic send_word(logic signed [31:0] comp, logic mark);
        start <= 1'b1;
        component <= comp;
        last_in_set <= mark;
        @(posedge clk);
        while (busy) @(posedge clk);
        start <= 1'b0;
        void'(predict_centroid(comp, mark));
        @(posedge clk);
    endtask

    task automatic wait_drain();
        while (expected_q.size() != 0) @(posedge clk);
        repeat (3000) @(posedge clk);
    endtask

    task automatic write_dims(logic [4:0] v);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        dims_reg = v;
        clear_stats();
    endtask

    function automatic logic signed [31:0] rand_comp();
        unique case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 0;
            3: return $signed($urandom_range(0, 4095)) - 2048;
            default: return $urandom();
        endcase
    endfunction

    row_t rows [$];
    int n_items = 0;

    initial
    begin
        row_t rw;
        int nd;
        logic [4:0] dim_opts [6];
        dims_reg = 1;
        for (int j = 0; j < NDIM; j++)
        begin
            pt_buf[j] = 0; min_acc[j] = 0; max_acc[j] = 0;
        end
        clear_stats();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at dims 1 after reset: single-point sets give mean = component
        rows = '{
            '{32'sh7FFFFFFF, 1'b1, 1'b1, 32'sh7FFFFFFF},
            '{32'sh80000000, 1'b1, 1'b1, 32'sh80000000},
            '{32'sh00000000, 1'b1, 1'b1, 32'sh00000000},
            '{32'sh00010000, 1'b0, 1'b0, 0},
            '{32'shFFFF0000, 1'b1, 1'b0, 0},
            '{32'sh00000001, 1'b0, 1'b0, 0},
            '{32'sh00000003, 1'b0, 1'b0, 0},
            '{32'shFFFFFFFF, 1'b1, 1'b0, 0}
        };
        foreach (rows[i])
        begin
            rw = rows[i];
            if (rw.fixed)
            begin
                if (expected_q.size() != 0) wait_drain();
            end
            send_word(rw.comp, rw.mark);
            if (rw.fixed && expected_q.size() == 1 && expected_q[0].avg !== rw.mean0)
            begin
                $error("mean exp %0d got %0d", rw.mean0, expected_q[0].avg);
                errors++;
            end
            n_items++;
        end

        // dims 16 and the out-of-range settings, with marks on inner components
        write_dims(5'd16);
        for (int i = 0; i < 16; i++)
        begin
            send_word(i[0] ? 32'sh7FFFFFFF : 32'sh80000000, i == 15);
            n_items++;
        end
        write_dims(5'd0);
        send_word(32'sh00020000, 1'b1);
        write_dims(5'd31);
        for (int i = 0; i < 16; i++) send_word(rand_comp(), 1'b1);
        write_dims(5'd3);
        send_word(5, 1'b1);
        send_word(0, 1'b1);
        send_word(0, 1'b1);
        n_items += 20;

        dim_opts = '{5'd1, 5'd2, 5'd4, 5'd7, 5'd16, 5'd0};
        while (n_items < 420)
        begin
            write_dims(dim_opts[$urandom_range(0, 5)]);
            nd = dims_eff();
            repeat ($urandom_range(1, 3))
            begin
                int pts;
                pts = $urandom_range(1, 5);
                for (int p = 0; p < pts; p++)
                    for (int k = 0; k < nd; k++)
                    begin
                        // marks on inner components are noise
                        send_word(rand_comp(),
                            (k == nd - 1) ? (p == pts - 1) : ($urandom_range(0, 3) == 0));
                        n_items++;
                        idle_gap();
                    end
            end
        end
        wait_drain();
        $display("covered %0d component words, %0d sets, %0d result words",
                 n_items, n_sets, n_results);
        if (errors == 0 && expected_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
